FILE: hw/rtl/grs_pkg.sv
package grs_pkg;

  localparam int unsigned GS_W  = 5;
  localparam int unsigned VAL_W = 32;

  typedef enum logic [1:0] {
    S_IDLE  = 2'b01,
    S_FLUSH = 2'b10
  } grs_state_e;

  typedef struct packed {
    logic push;
    logic pop;
  } grs_cmd_t;

  typedef struct packed {
    logic flush_req;
    logic can_read;
    logic last_pop;
    logic held_zero;
    logic held_full;
  } grs_sts_t;

endpackage

FILE: hw/rtl/grs_if.sv
interface grs_in_if import grs_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] value;
  logic                    list_end;

  modport source (output valid, value, list_end, input ready);
  modport sink   (input valid, value, list_end, output ready);
endinterface

interface grs_out_if import grs_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] value_res;
  logic                    group_end;
  logic                    list_last;

  modport source (output valid, value_res, group_end, list_last, input ready);
  modport sink   (input valid, value_res, group_end, list_last, output ready);
endinterface

FILE: hw/rtl/grs_ram.sv
module grs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/grs_ctrl.sv
module grs_ctrl import grs_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  grs_sts_t sts_i,
  output grs_cmd_t cmd_o
);

  grs_state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = (state_q == S_IDLE);
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.push = 1'b1;
          if (sts_i.flush_req) begin
            state_d = S_FLUSH;
          end
        end
      end
      S_FLUSH: begin
        if (sts_i.can_read) begin
          cmd_o.pop = 1'b1;
          if (sts_i.last_pop) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: hw/rtl/grs_dp.sv
module grs_dp import grs_pkg::*; #(
  parameter int unsigned MAX_GROUP  = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [GS_W-1:0]         cfg_wdata_i,
  input  logic signed [VAL_W-1:0] value_i,
  input  logic                    list_end_i,
  input  grs_cmd_t                cmd_i,
  output grs_sts_t                sts_o,
  grs_out_if.source               out_o
);

  localparam int unsigned AW = $clog2(MAX_GROUP);
  localparam int unsigned CW = $clog2(MAX_GROUP + 1);
  localparam int unsigned EW = (CW > GS_W) ? CW : GS_W;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic             group_end;
    logic             list_last;
  } res_t;

  logic [GS_W-1:0] group_size_q;
  logic [CW-1:0]   held_q, held_d, held_dec;
  logic            last_q;
  logic            rd_valid_q;
  logic            pend_ge_q, pend_ll_q;
  logic [1:0]      occ_q, occ_d, wr_slot;
  res_t            slot0_q, slot0_d, slot1_q, slot1_d, new_res;
  logic            out_pop;

  logic [EW-1:0]   gs_w, max_w, eff_w, held_inc_w;
  logic [AW-1:0]   ram_addr;
  logic [DATA_WIDTH-1:0] ram_rdata;

  // effective group size: 0 and 1 act as 1, large values clamp
  always_comb begin
    gs_w  = EW'(group_size_q);
    max_w = EW'(MAX_GROUP);
    if (gs_w <= EW'(1)) begin
      eff_w = EW'(1);
    end else if (gs_w > max_w) begin
      eff_w = max_w;
    end else begin
      eff_w = gs_w;
    end
    held_inc_w = EW'(held_q) + EW'(1);
  end

  assign held_dec = held_q - CW'(1);
  assign ram_addr = cmd_i.pop ? held_dec[AW-1:0] : held_q[AW-1:0];

  grs_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (MAX_GROUP)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (cmd_i.push),
    .re_i    (cmd_i.pop),
    .addr_i  (ram_addr),
    .wdata_i (DATA_WIDTH'($unsigned(value_i))),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    held_d = held_q;
    if (cmd_i.push) begin
      held_d = held_q + CW'(1);
    end else if (cmd_i.pop) begin
      held_d = held_dec;
    end
  end

  // two-entry output buffer, slot0 is the head
  assign out_pop = out_o.valid && out_o.ready;
  assign occ_d   = occ_q - {1'b0, out_pop} + {1'b0, rd_valid_q};
  assign wr_slot = occ_q - {1'b0, out_pop};

  always_comb begin
    new_res.value     = VAL_W'(ram_rdata);
    new_res.group_end = pend_ge_q;
    new_res.list_last = pend_ll_q;
    slot0_d = slot0_q;
    slot1_d = slot1_q;
    if (out_pop) begin
      slot0_d = slot1_q;
    end
    if (rd_valid_q) begin
      if (wr_slot == 2'd0) begin
        slot0_d = new_res;
      end else begin
        slot1_d = new_res;
      end
    end
  end

  always_comb begin
    sts_o.flush_req = (held_inc_w >= eff_w) || list_end_i;
    sts_o.can_read  = (occ_d < 2'd2);
    sts_o.last_pop  = (held_q == CW'(1));
    sts_o.held_zero = (held_q == '0);
    sts_o.held_full = (held_q == CW'(MAX_GROUP));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_size_q <= GS_W'(1);
      held_q       <= '0;
      last_q       <= 1'b0;
      rd_valid_q   <= 1'b0;
      pend_ge_q    <= 1'b0;
      pend_ll_q    <= 1'b0;
      occ_q        <= '0;
    end else begin
      if (cfg_we_i) begin
        group_size_q <= cfg_wdata_i;
      end
      held_q     <= held_d;
      rd_valid_q <= cmd_i.pop;
      if (cmd_i.push) begin
        last_q <= list_end_i;
      end
      if (cmd_i.pop) begin
        pend_ge_q <= sts_o.last_pop;
        pend_ll_q <= sts_o.last_pop && last_q;
      end
      occ_q <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot0_q <= slot0_d;
    slot1_q <= slot1_d;
  end

  assign out_o.valid     = (occ_q != 2'd0);
  assign out_o.value_res = $signed(slot0_q.value);
  assign out_o.group_end = slot0_q.group_end;
  assign out_o.list_last = slot0_q.list_last;

endmodule

FILE: hw/rtl/group_reverse_stream.sv
// group_reverse_stream
// Reverses a stream of values in groups of group_size.
// in_i  (valid/ready): one value per transaction, list_end on the final one.
// out_o (valid/ready): value_res, group_end on the last value of a group,
//   list_last on the final value of the whole list.
// cfg_we_i/cfg_wdata_i: writes group_size (0 or 1 = pass through, above
//   MAX_GROUP acts as MAX_GROUP). Write only while the block is idle.
// Each input transaction is a push onto the stack RAM.
// A full group or list end starts a flush: one stack read per cycle
// while the output buffer has room, input ready low meanwhile. The
// single-port stack RAM never does a push and a pop at once.
// A two-entry output buffer sits after the RAM; input is taken again as
// soon as all reads are issued, while results still drain.
// When out_o stalls the flush pauses once the buffer is full; nothing is lost.
// Reset: stack empty, group_size = 1, no output pending.
module group_reverse_stream import grs_pkg::*; #(
  parameter int unsigned MAX_GROUP  = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [GS_W-1:0] cfg_wdata_i,
  grs_in_if.sink          in_i,
  grs_out_if.source       out_o
);

  grs_cmd_t cmd;
  grs_sts_t sts;
  logic     in_ready;

  assign in_i.ready = in_ready;

  grs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  grs_dp #(
    .MAX_GROUP  (MAX_GROUP),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .value_i     (in_i.value),
    .list_end_i  (in_i.list_end),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_o       (out_o)
  );

  a_flush_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && sts.flush_req) |=> !in_i.ready)
    else $error("input accepted right after a flushing transaction");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.pop |-> !sts.held_zero)
    else $error("stack pop while empty");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.push |-> !sts.held_full)
    else $error("stack push while full");

  a_last_ends_group: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.list_last) |-> out_o.group_end)
    else $error("list_last without group_end");

endmodule

FILE: verif/group_reverse_checker.sv
module group_reverse_checker import grs_pkg::*; #(
  parameter int unsigned MAX_GROUP = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [GS_W-1:0] cfg_wdata_i,
  grs_in_if               in_i,
  grs_out_if              out_i,
  output int unsigned     error_count_o,
  output int unsigned     pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [VAL_W-1:0] value_res;
    logic                    group_end;
    logic                    list_last;
  } reordered_item_t;

  logic [GS_W-1:0]  group_size_q;
  logic [VAL_W-1:0] held_values [MAX_GROUP];
  int unsigned      held_count;
  reordered_item_t  reordered_q [$];

  initial begin
    error_count_o = 0;
    pending_o     = 0;
    group_size_q  = 1;
    held_count    = 0;
  end

  function automatic void push_and_flush(input logic [VAL_W-1:0] v, input logic list_end);
    int unsigned     eff;
    reordered_item_t r;
    if (group_size_q <= 1) eff = 1;
    else if (group_size_q > MAX_GROUP) eff = MAX_GROUP;
    else eff = group_size_q;
    if (held_count < MAX_GROUP) begin
      held_values[held_count] = v;
      held_count++;
    end
    if (held_count >= eff || list_end) begin
      while (held_count > 0) begin
        held_count--;
        r.value_res = held_values[held_count];
        r.group_end = (held_count == 0);
        r.list_last = (held_count == 0) && list_end;
        reordered_q.push_back(r);
      end
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    reordered_item_t want;
    reordered_item_t got;
    if (!rst_ni) begin
      group_size_q = 1;
      held_count   = 0;
      reordered_q.delete();
    end else begin
      if (out_i.valid && out_i.ready) begin
        got.value_res = out_i.value_res;
        got.group_end = out_i.group_end;
        got.list_last = out_i.list_last;
        if (reordered_q.size() == 0) begin
          if (error_count_o < 10)
            $display("unexpected transaction: value_res=%0d group_end=%0b list_last=%0b",
                     got.value_res, got.group_end, got.list_last);
          error_count_o++;
        end else begin
          want = reordered_q.pop_front();
          if (got.value_res !== want.value_res || got.group_end !== want.group_end ||
              got.list_last !== want.list_last) begin
            if (error_count_o < 10)
              $display({"mismatch: expected value_res=%0d group_end=%0b list_last=%0b,",
                        " got value_res=%0d group_end=%0b list_last=%0b"},
                       want.value_res, want.group_end, want.list_last,
                       got.value_res, got.group_end, got.list_last);
            error_count_o++;
          end
        end
      end
      if (in_i.valid && in_i.ready)
        push_and_flush(in_i.value, in_i.list_end);
      if (cfg_we_i)
        group_size_q = cfg_wdata_i;
    end
    pending_o = reordered_q.size();
  end

endmodule

FILE: verif/group_reverse_stream_test.sv
module group_reverse_stream_test;
  timeunit 1ns;
  timeprecision 1ps;
  import grs_pkg::*;

  localparam int unsigned MAX_GROUP    = 16;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned PHASE_ITEMS  = 28;

  logic            clk_i;
  logic            rst_ni;
  logic            cfg_we;
  logic [GS_W-1:0] cfg_wdata;
  int unsigned     error_count;
  int unsigned     pending;
  int unsigned     send_idle_pct;
  int unsigned     recv_idle_pct;

  grs_in_if  in_ch ();
  grs_out_if out_ch ();

  group_reverse_stream #(
    .MAX_GROUP  (MAX_GROUP),
    .DATA_WIDTH (VAL_W)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  group_reverse_checker #(
    .MAX_GROUP (MAX_GROUP)
  ) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .in_i          (in_ch),
    .out_i         (out_ch),
    .error_count_o (error_count),
    .pending_o     (pending)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    out_ch.ready = ($urandom_range(99) >= recv_idle_pct);
  end

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  task automatic wait_drained();
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_group_size(input logic [GS_W-1:0] gs);
    wait_drained();
    cfg_we    = 1'b1;
    cfg_wdata = gs;
    @(negedge clk_i);
    cfg_we    = 1'b0;
  endtask

  task automatic send_value(input logic signed [VAL_W-1:0] v, input logic list_end);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid    = 1'b1;
    in_ch.value    = v;
    in_ch.list_end = list_end;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
    in_ch.valid = 1'b0;
  endtask

  function automatic logic signed [VAL_W-1:0] random_value();
    case ($urandom_range(9))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [GS_W-1:0] random_group_size();
    case ($urandom_range(9))
      0:       return '0;
      1:       return GS_W'(1);
      2:       return GS_W'(MAX_GROUP);
      3:       return GS_W'($urandom_range(MAX_GROUP + 1, 31));
      default: return GS_W'($urandom_range(2, 6));
    endcase
  endfunction

  initial begin : stimulus
    logic [GS_W-1:0] gs;
    int unsigned     eff;
    int unsigned     len;
    int unsigned     sent;
    rst_ni         = 1'b0;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    in_ch.valid    = 1'b0;
    in_ch.value    = '0;
    in_ch.list_end = 1'b0;
    out_ch.ready   = 1'b0;
    send_idle_pct  = 14;
    recv_idle_pct  = 82;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // pass-through at reset size
    send_value(32'h7FFF_FFFF, 1'b0);
    send_value(32'h8000_0000, 1'b0);
    send_value(32'h0000_0000, 1'b0);
    send_value(32'hFFFF_FFFF, 1'b1);
    write_group_size(0);
    send_value(32'h5A5A_A5A5, 1'b1);
    // full groups then a partial one at list end
    write_group_size(3);
    send_value(32'hFFFF_0000, 1'b0);
    send_value(32'h0000_FFFF, 1'b0);
    send_value(32'hA5A5_5A5A, 1'b0);
    send_value(32'h0000_0001, 1'b0);
    send_value(32'h8000_0001, 1'b1);
    // one-element list
    write_group_size(4);
    send_value(32'h1234_5678, 1'b1);
    // size lowered while values are held
    write_group_size(8);
    send_value(32'h0000_0011, 1'b0);
    send_value(32'h0000_0022, 1'b0);
    send_value(32'h0000_0033, 1'b0);
    write_group_size(2);
    send_value(32'h0000_0044, 1'b0);

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 14 : (phase == 1) ? 82 : 0;
      recv_idle_pct = (phase == 0) ? 82 : (phase == 1) ? 14 : 0;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if (sent == 0 && phase < 2) gs = (phase == 0) ? GS_W'(MAX_GROUP) : GS_W'(31);
        else gs = random_group_size();
        write_group_size(gs);
        if (gs <= 1) eff = 1;
        else if (gs > MAX_GROUP) eff = MAX_GROUP;
        else eff = gs;
        if (sent == 0 && phase < 2) len = MAX_GROUP + 1;
        else len = $urandom_range(1, (2 * eff + 1 < 20) ? 2 * eff + 1 : 20);
        for (int unsigned i = 0; i < len; i++) begin
          if ($urandom_range(9) == 0) wait_drained();
          send_value(random_value(), i == len - 1);
          sent++;
        end
      end
    end

    wait_drained();
    if (error_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
